// ===== hw/rtl/rnph_pkg.sv =====
// ----------------------------------------------------------------------------
// rnph_pkg
// shared types and codes of the ring node packet handler
// ----------------------------------------------------------------------------
package rnph_pkg;

    // command kinds carried in s_tuser
    localparam logic [2:0] KIND_RX       = 3'd0;
    localparam logic [2:0] KIND_VALIDATE = 3'd1;
    localparam logic [2:0] KIND_DISCOVER = 3'd2;
    localparam logic [2:0] KIND_CLEANUP  = 3'd3;
    localparam logic [2:0] KIND_PING     = 3'd4;

    // packet type characters
    localparam logic [7:0] PKT_VALIDATE  = 8'h31; // '1'
    localparam logic [7:0] PKT_DISCOVER  = 8'h32; // '2'
    localparam logic [7:0] PKT_SIZE      = 8'h33; // '3'
    localparam logic [7:0] PKT_PING      = 8'h34; // '4'
    localparam logic [7:0] PKT_PING_ACK  = 8'h35; // '5'
    localparam logic [7:0] PKT_CLEANUP   = 8'h38; // '8'
    localparam logic [7:0] PKT_VALID_ACK = 8'h39; // '9'
    localparam logic [7:0] PKT_TEXT_HEAD = 8'h61; // 'a'
    localparam logic [7:0] PKT_TEXT_PART = 8'h62; // 'b'

    // other characters and constants
    localparam logic [7:0]  CHR_A       = 8'h61;         // 'a'
    localparam logic [7:0]  CHR_X       = 8'h78;         // 'x'
    localparam logic [7:0]  CHR_ONE     = 8'd49;         // '1'
    localparam logic [7:0]  SIZE_OFFSET = 8'd96;
    localparam logic [31:0] TXT_REEN    = 32'h6E656572;  // "reen", first char lowest

    localparam int DATA_IN_W  = 128;
    localparam int DATA_OUT_W = 160;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  pkt_type;
        logic [63:0] content_lo;
        logic [39:0] content_hi;
        logic [7:0]  src_addr;
        logic [7:0]  dst_addr;
    } rx_item_t;

    typedef struct packed {
        logic        send;
        logic [7:0]  tx_type;
        logic [63:0] tx_content_lo;
        logic [39:0] tx_content_hi;
        logic [7:0]  tx_src;
        logic [7:0]  tx_dst;
        logic [7:0]  node_address;
        logic [7:0]  node_total;
        logic        ring_valid;
        logic        ping_found;
        logic [7:0]  parts_remaining;
        logic        text_complete;
    } result_t;

endpackage

// ===== hw/rtl/rnph_in_reg.sv =====
// ----------------------------------------------------------------------------
// rnph_in_reg
// input register: unpacks the slave stream and holds one packet
// ----------------------------------------------------------------------------
module rnph_in_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rnph_pkg::DATA_IN_W-1:0]      s_tdata,
    input  logic [2:0]                          s_tuser,
    input  logic                                advance,
    output logic                                item_valid,
    output rnph_pkg::rx_item_t                  item
);
    import rnph_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;

    // register frees when empty or when its packet moves on
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.kind       <= s_tuser;
            item_reg.pkt_type   <= s_tdata[7:0];
            item_reg.content_lo <= s_tdata[71:8];
            item_reg.content_hi <= s_tdata[111:72];
            item_reg.src_addr   <= s_tdata[119:112];
            item_reg.dst_addr   <= s_tdata[127:120];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/rnph_core.sv =====
// ----------------------------------------------------------------------------
// rnph_core
// node state and per-packet decision logic
// ----------------------------------------------------------------------------
module rnph_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  rnph_pkg::rx_item_t  item,
    output rnph_pkg::result_t   result
);
    import rnph_pkg::*;

    logic [7:0] own_reg,    own_next;
    logic [7:0] size_reg,   size_next;
    logic       valid_reg,  valid_next;
    logic       ping_reg,   ping_next;
    logic [7:0] parts_reg,  parts_next;

    logic        dst_own;
    logic        src_own;
    logic        fwd;
    logic [7:0]  rx0;
    logic [7:0]  own_inc;
    logic [63:0] fwd_lo;
    logic [7:0]  parts_dec;

    assign dst_own   = (item.dst_addr == own_reg);
    assign src_own   = (item.src_addr == own_reg);
    assign rx0       = item.content_lo[7:0];
    assign own_inc   = rx0 + 8'd1;
    assign parts_dec = parts_reg - 8'd1;

    always_comb
    begin
        own_next   = own_reg;
        size_next  = size_reg;
        valid_next = valid_reg;
        ping_next  = ping_reg;
        parts_next = parts_reg;
        fwd        = 1'b0;
        fwd_lo     = item.content_lo;
        result     = '0;

        case (item.kind)
            KIND_RX:
            begin
                case (item.pkt_type)
                    PKT_VALIDATE:
                    begin
                        if (dst_own)
                        begin
                            valid_next           = 1'b1;
                            result.send          = 1'b1;
                            result.tx_type       = PKT_VALID_ACK;
                            result.tx_src        = own_reg;
                            result.tx_dst        = own_reg;
                            result.tx_content_lo = {56'd0, CHR_ONE};
                        end
                        else
                        begin
                            fwd_lo   = {item.content_lo[63:40], 8'h00, TXT_REEN};
                            fwd      = 1'b1;
                            own_next = 8'd0;
                        end
                    end
                    PKT_DISCOVER:
                    begin
                        if (!dst_own)
                        begin
                            own_next = own_inc;
                            fwd_lo   = {item.content_lo[63:16], 8'h00, own_inc};
                            fwd      = 1'b1;
                        end
                        else
                        begin
                            size_next            = rx0 - SIZE_OFFSET;
                            result.send          = 1'b1;
                            result.tx_type       = PKT_SIZE;
                            result.tx_src        = own_reg;
                            result.tx_dst        = own_reg;
                            result.tx_content_lo = {56'd0, rx0};
                        end
                    end
                    PKT_SIZE:
                    begin
                        if (!dst_own)
                        begin
                            size_next = rx0 - SIZE_OFFSET;
                            fwd       = 1'b1;
                        end
                    end
                    PKT_PING:
                    begin
                        if (dst_own)
                        begin
                            result.send          = 1'b1;
                            result.tx_type       = PKT_PING_ACK;
                            result.tx_src        = own_reg;
                            result.tx_dst        = item.src_addr;
                            result.tx_content_lo = {56'd0, CHR_ONE};
                        end
                        else if (!src_own)
                        begin
                            fwd = 1'b1;
                        end
                    end
                    PKT_PING_ACK:
                    begin
                        if (dst_own)
                        begin
                            ping_next = (rx0 == CHR_ONE);
                        end
                        else
                        begin
                            fwd = 1'b1;
                        end
                    end
                    PKT_CLEANUP:
                    begin
                        if (!dst_own)
                        begin
                            own_next = 8'd0;
                            fwd      = 1'b1;
                        end
                    end
                    PKT_VALID_ACK:
                    begin
                        if (rx0 == CHR_ONE)
                        begin
                            valid_next = 1'b1;
                        end
                        fwd = !dst_own;
                    end
                    PKT_TEXT_HEAD:
                    begin
                        if (!dst_own)
                        begin
                            fwd = 1'b1;
                        end
                        else
                        begin
                            parts_next = rx0;
                        end
                    end
                    PKT_TEXT_PART:
                    begin
                        if (dst_own)
                        begin
                            parts_next           = parts_dec;
                            result.text_complete = (parts_dec == 8'd0);
                        end
                        else if (!src_own)
                        begin
                            fwd = 1'b1;
                        end
                    end
                    default:
                    begin
                        // unknown type: absorbed
                    end
                endcase

                if (fwd)
                begin
                    result.send          = 1'b1;
                    result.tx_type       = item.pkt_type;
                    result.tx_src        = item.src_addr;
                    result.tx_dst        = item.dst_addr;
                    result.tx_content_lo = fwd_lo;
                    result.tx_content_hi = item.content_hi;
                end
            end
            KIND_VALIDATE:
            begin
                own_next       = CHR_A;
                size_next      = 8'd0;
                valid_next     = 1'b0;
                result.send    = 1'b1;
                result.tx_type = PKT_VALIDATE;
                result.tx_src  = CHR_A;
                result.tx_dst  = CHR_A;
            end
            KIND_DISCOVER:
            begin
                result.send          = 1'b1;
                result.tx_type       = PKT_DISCOVER;
                result.tx_src        = CHR_A;
                result.tx_dst        = CHR_A;
                result.tx_content_lo = {56'd0, CHR_A};
            end
            KIND_CLEANUP:
            begin
                own_next       = CHR_X;
                result.send    = 1'b1;
                result.tx_type = PKT_CLEANUP;
                result.tx_src  = CHR_X;
                result.tx_dst  = CHR_X;
            end
            KIND_PING:
            begin
                ping_next      = 1'b0;
                result.send    = 1'b1;
                result.tx_type = PKT_PING;
                result.tx_src  = own_reg;
                result.tx_dst  = item.dst_addr;
            end
            default:
            begin
                // unused kinds: ignored
            end
        endcase

        result.node_address    = own_next;
        result.node_total      = size_next;
        result.ring_valid      = valid_next;
        result.ping_found      = ping_next;
        result.parts_remaining = parts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg   <= 8'd0;
            size_reg  <= 8'd0;
            valid_reg <= 1'b0;
            ping_reg  <= 1'b0;
            parts_reg <= 8'd0;
        end
        else if (step)
        begin
            own_reg   <= own_next;
            size_reg  <= size_next;
            valid_reg <= valid_next;
            ping_reg  <= ping_next;
            parts_reg <= parts_next;
        end
    end

endmodule

// ===== hw/rtl/rnph_out_reg.sv =====
// ----------------------------------------------------------------------------
// rnph_out_reg
// result register: packs one result onto the master stream
// ----------------------------------------------------------------------------
module rnph_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  rnph_pkg::result_t                   result,
    output logic                                advance,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rnph_pkg::DATA_OUT_W-1:0]     m_tdata,
    output logic [0:0]                          m_tuser
);
    import rnph_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // slot frees when empty or when the receiver takes it
    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.send;
    assign m_tdata  = {5'd0,
                       res_reg.text_complete,
                       res_reg.parts_remaining,
                       res_reg.ping_found,
                       res_reg.ring_valid,
                       res_reg.node_total,
                       res_reg.node_address,
                       res_reg.tx_dst,
                       res_reg.tx_src,
                       res_reg.tx_content_hi,
                       res_reg.tx_content_lo,
                       res_reg.tx_type};

endmodule

// ===== hw/rtl/ring_node_packet_handler_top.sv =====
// ----------------------------------------------------------------------------
// ring_node_packet_handler_top
// token ring node that relays, answers or absorbs 16-byte packets
// ----------------------------------------------------------------------------
// usage
//   slave stream carries one received packet or local command per transaction;
//   s_tuser holds the command kind, s_tdata the 128-bit packet
//   master stream returns exactly one result per input transaction; m_tuser
//   flags that a packet goes to the next node, m_tdata holds that packet
//   (zeros when nothing is sent) and the node status after the step
//   path: an accepted transaction passes the input register, then the
//   result register, before its result shows on m_tvalid
//   throughput: one transaction per cycle while m_tready is high; the node
//   state feeds back from the decision logic into its own registers, so
//   consecutive packets see each other's updates without bubbles
//   reset: address, node count, flags and text part count clear to zero,
//   both pipeline registers empty
//   stall: when m_tready is low the result register holds, the input register
//   keeps one more transaction, then s_tready drops until the receiver
//   takes the result
// ----------------------------------------------------------------------------
module ring_node_packet_handler_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pkt_type, content_lo, content_hi, src_addr, dst_addr
    input  logic [rnph_pkg::DATA_IN_W-1:0]      s_tdata,
    // kind
    input  logic [2:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tx_type, tx_content_lo, tx_content_hi, tx_src, tx_dst, node_address,
    // node_total, ring_valid, ping_found, parts_remaining, text_complete, pad
    output logic [rnph_pkg::DATA_OUT_W-1:0]     m_tdata,
    // send
    output logic [0:0]                          m_tuser
);
    import rnph_pkg::*;

    rx_item_t item;
    result_t  result;
    logic     item_valid;
    logic     advance;
    logic     step;

    // a held packet is processed once, in the cycle it moves to the output
    assign step = item_valid && advance;

    rnph_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rnph_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    rnph_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .result    (result),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // no transmission means an all-zero packet
    a_idle_packet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[127:0] == 128'd0))
        else $error("packet fields nonzero without send");

    // text completion comes with an empty count and no transmission
    a_text_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[154]) |-> ((m_tdata[153:146] == 8'd0) && !m_tuser[0]))
        else $error("text complete with parts left or send");

    // input side backs up only behind a stalled result
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without output stall");

endmodule
